### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the selector RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define LES_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define LES_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

### rtl/les_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// les_pkg
// Types, codes and helpers of the latency-aware engine selector.
// ----------------------------------------------------------------------------
package les_pkg;

	localparam int NUM_BUCKETS = 11;
	localparam logic [19:0] BUCKET_MIN = 20'd128;
	localparam logic [31:0] SCORE_UNTRIED = 32'd256;

	localparam logic [2:0] REQ_ORDER  = 3'd0;
	localparam logic [2:0] REQ_REPORT = 3'd1;
	localparam logic [2:0] REQ_FAIL   = 3'd2;
	localparam logic [2:0] REQ_TICK   = 3'd3;
	localparam logic [2:0] REQ_FORCE  = 3'd4;

	localparam logic [1:0] MODE_STRICT = 2'd0;
	localparam logic [1:0] MODE_ADAPT  = 2'd1;
	localparam logic [1:0] MODE_NOFAIL = 2'd2;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	localparam logic [2:0] CFG_MODE     = 3'd0;
	localparam logic [2:0] CFG_WINDOW   = 3'd1;
	localparam logic [2:0] CFG_COOLDOWN = 3'd2;
	localparam logic [2:0] CFG_ELIGIBLE = 3'd3;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [2:0]  child;
		logic [19:0] job_size;
		logic [23:0] lat_us;
		logic        set_healthy;
	} les_in_t;

	typedef struct packed {
		logic [2:0] child_index;
		logic       last;
		logic       none_available;
		logic [7:0] healthy_mask;
	} les_out_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic cap;
		logic refresh;
		logic scan_clr;
		logic scan_rd;
		logic scan_cmp;
		logic prep;
		logic emit;
		logic ack;
		logic rep_rd;
		logic div_start;
		logic rep_wr;
		logic fail;
		logic force_h;
		logic tick;
	} les_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic child_ok;
		logic scan_last;
		logic emit_last;
		logic rep_valid;
		logic div_done;
		logic out_free;
	} les_sts_t;

	function automatic logic [3:0] bucket_of(input logic [19:0] size);
		logic [3:0] b;
		b = 4'd0;
		for (int i = 0; i < NUM_BUCKETS - 1; i++) begin
			if (size >= (BUCKET_MIN << i)) b = 4'(i + 1);
		end
		return b;
	endfunction

endpackage

### rtl/les_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// les_div
// Restoring divider, 32-bit dividend by 16-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module les_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [15:0] divisor,
	output logic        busy,
	output logic        done,
	output logic [31:0] quotient
);
	logic        busy_q, done_q;
	logic [4:0]  cnt_q;
	logic [16:0] rem_q;
	logic [31:0] quo_q;
	logic [15:0] dvs_q;
	logic [16:0] rem_sh;

	assign rem_sh = {rem_q[15:0], quo_q[31]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (rem_sh >= {1'b0, dvs_q}) begin
				rem_q <= rem_sh - {1'b0, dvs_q};
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;
endmodule

### rtl/les_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// les_ctrl
// Sequencer of the selector: steps each item through the datapath.
// ----------------------------------------------------------------------------
module les_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [2:0]          req_type,
	input  les_pkg::les_sts_t   sts,
	output les_pkg::les_cmd_t   cmd
);
	import les_pkg::*;
	`include "assert_macros.svh"

	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_REFRESH = 4'd1;
	localparam logic [3:0] ST_SCAN_RD = 4'd2;
	localparam logic [3:0] ST_SCAN_CM = 4'd3;
	localparam logic [3:0] ST_PREP    = 4'd4;
	localparam logic [3:0] ST_EMIT    = 4'd5;
	localparam logic [3:0] ST_REP_RD  = 4'd6;
	localparam logic [3:0] ST_REP_CHK = 4'd7;
	localparam logic [3:0] ST_DIV     = 4'd8;
	localparam logic [3:0] ST_REP_WR  = 4'd9;
	localparam logic [3:0] ST_FAIL    = 4'd10;
	localparam logic [3:0] ST_FORCE   = 4'd11;
	localparam logic [3:0] ST_TICK    = 4'd12;
	localparam logic [3:0] ST_TREF    = 4'd13;
	localparam logic [3:0] ST_ACK     = 4'd14;

	logic [3:0] state_q, state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.cap = 1'b1;
					case (req_type)
						REQ_ORDER:  state_d = ST_REFRESH;
						REQ_REPORT: state_d = ST_REP_RD;
						REQ_FAIL:   state_d = ST_FAIL;
						REQ_TICK:   state_d = ST_TICK;
						REQ_FORCE:  state_d = ST_FORCE;
						default:    state_d = ST_IDLE;
					endcase
				end
			end
			ST_REFRESH: begin
				cmd.refresh  = 1'b1;
				cmd.scan_clr = 1'b1;
				state_d      = ST_SCAN_RD;
			end
			ST_SCAN_RD: begin
				cmd.scan_rd = 1'b1;
				state_d     = ST_SCAN_CM;
			end
			ST_SCAN_CM: begin
				cmd.scan_cmp = 1'b1;
				state_d      = sts.scan_last ? ST_PREP : ST_SCAN_RD;
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.emit_last) state_d = ST_IDLE;
				end
			end
			ST_REP_RD: begin
				if (sts.child_ok) begin
					cmd.rep_rd = 1'b1;
					state_d    = ST_REP_CHK;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_REP_CHK: begin
				if (sts.rep_valid) begin
					cmd.div_start = 1'b1;
					state_d       = ST_DIV;
				end else begin
					state_d = ST_REP_WR;
				end
			end
			ST_DIV: begin
				if (sts.div_done) state_d = ST_REP_WR;
			end
			ST_REP_WR: begin
				cmd.rep_wr = 1'b1;
				state_d    = ST_IDLE;
			end
			ST_FAIL: begin
				cmd.fail = 1'b1;
				state_d  = ST_ACK;
			end
			ST_FORCE: begin
				cmd.force_h = 1'b1;
				state_d     = ST_ACK;
			end
			ST_TICK: begin
				cmd.tick = 1'b1;
				state_d  = ST_TREF;
			end
			ST_TREF: begin
				cmd.refresh = 1'b1;
				state_d     = ST_ACK;
			end
			ST_ACK: begin
				if (sts.out_free) begin
					cmd.ack = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`LES_ASSERT(a_emit_free, clk, arst_n, (cmd.emit || cmd.ack) |-> sts.out_free, "result issued into a full output slot")
	`LES_ASSERT(a_div_needed, clk, arst_n, cmd.div_start |-> (state_q == ST_REP_CHK && sts.rep_valid), "divider started without a prior sample")
endmodule

### rtl/les_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// les_dp
// Selector datapath: config, health, cooldowns, latency memory, try order.
// ----------------------------------------------------------------------------
module les_dp #(
	parameter int NUM_ENGINES = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  les_pkg::les_in_t   in_item,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  les_pkg::les_cmd_t  cmd,
	output les_pkg::les_sts_t  sts,
	output logic               out_valid,
	input  logic               out_ready,
	output les_pkg::les_out_t  out_item
);
	import les_pkg::*;
	`include "assert_macros.svh"

	localparam int EW    = (NUM_ENGINES > 1) ? $clog2(NUM_ENGINES) : 1;
	localparam int DEPTH = NUM_ENGINES * NUM_BUCKETS;
	localparam int AW    = $clog2(DEPTH);

	function automatic logic [EW-1:0] lowest(input logic [NUM_ENGINES-1:0] v);
		logic [EW-1:0] r;
		r = '0;
		for (int i = NUM_ENGINES - 1; i >= 0; i--) begin
			if (v[i]) r = EW'(i);
		end
		return r;
	endfunction

	// configuration
	logic [1:0]  mode_q;
	logic [15:0] window_q;
	logic [31:0] cool_ticks_q;
	logic [7:0]  elig_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_STRICT;
			window_q     <= 16'd1;
			cool_ticks_q <= '0;
			elig_q       <= 8'hFF;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MODE:     mode_q <= (cfg_data[1:0] == MODE_UNUSED) ? MODE_ADAPT
						: cfg_data[1:0];
				CFG_WINDOW:   window_q <= cfg_data[15:0];
				CFG_COOLDOWN: cool_ticks_q <= cfg_data;
				CFG_ELIGIBLE: elig_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// captured item
	les_in_t       item_q;
	logic [3:0]    bucket;
	logic          child_ok;
	logic [EW-1:0] child_e;

	always_ff @(posedge clk) begin
		if (cmd.cap) item_q <= in_item;
	end

	assign bucket   = bucket_of(item_q.job_size);
	assign child_ok = (int'(item_q.child) < NUM_ENGINES);
	assign child_e  = EW'(item_q.child);

	// health and cooldown
	logic [NUM_ENGINES-1:0] health_q;
	logic [31:0]            cool_q [NUM_ENGINES];
	logic [15:0]            health_ext;
	logic [15:0]            elig_ext;
	logic [NUM_ENGINES-1:0] elig_vec;

	assign health_ext = 16'(health_q);
	assign elig_ext   = {8'd0, elig_q};
	assign elig_vec   = elig_ext[NUM_ENGINES-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			health_q <= '1;
			for (int e = 0; e < NUM_ENGINES; e++) cool_q[e] <= '0;
		end else begin
			if (cmd.refresh) begin
				for (int e = 0; e < NUM_ENGINES; e++) begin
					if (!health_q[e] && cool_q[e] == 32'd0) health_q[e] <= 1'b1;
				end
			end
			if (cmd.tick) begin
				for (int e = 0; e < NUM_ENGINES; e++) begin
					if (!health_q[e] && cool_q[e] != 32'd0) cool_q[e] <= cool_q[e] - 32'd1;
				end
			end
			if ((cmd.fail || (cmd.force_h && !item_q.set_healthy)) && child_ok) begin
				health_q[child_e] <= 1'b0;
				cool_q[child_e]   <= cool_ticks_q;
			end
			if (cmd.force_h && item_q.set_healthy && child_ok) health_q[child_e] <= 1'b1;
		end
	end

	// latency memory and its valid bits
	logic [31:0]      lat_mem [DEPTH];
	logic [DEPTH-1:0] lat_vld_q;
	logic [31:0]      rd_data_s1;
	logic             rd_vld_s1;
	logic [EW-1:0]    eng_q;
	logic [EW-1:0]    rd_eng;
	logic [AW-1:0]    addr;
	logic             rd_en;
	logic [31:0]      wr_data;

	assign rd_eng = cmd.scan_rd ? eng_q : child_e;
	assign addr   = AW'(rd_eng) * AW'(NUM_BUCKETS) + AW'(bucket);
	assign rd_en  = cmd.scan_rd || cmd.rep_rd;

	always_ff @(posedge clk) begin
		if (cmd.rep_wr) lat_mem[addr] <= wr_data;
		if (rd_en) rd_data_s1 <= lat_mem[addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lat_vld_q <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (cmd.rep_wr) lat_vld_q[addr] <= 1'b1;
			if (rd_en) rd_vld_s1 <= lat_vld_q[addr];
		end
	end

	// running average update
	logic [31:0] new_val;
	logic        up;
	logic [31:0] quotient;
	logic        div_busy, div_done;
	logic [15:0] win_eff;

	assign new_val = {item_q.lat_us, 8'd0};
	assign up      = (new_val >= rd_data_s1);
	assign win_eff = (window_q == 16'd0) ? 16'd1 : window_q;

	les_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (up ? (new_val - rd_data_s1) : (rd_data_s1 - new_val)),
		.divisor  (win_eff),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (quotient)
	);

	assign wr_data = !rd_vld_s1 ? new_val
			: (up ? (rd_data_s1 + quotient) : (rd_data_s1 - quotient));

	// score scan
	logic          best_vld_q;
	logic [EW-1:0] best_q;
	logic [31:0]   best_score_q;
	logic [31:0]   score;
	logic          cand;

	assign score = rd_vld_s1 ? rd_data_s1 : SCORE_UNTRIED;
	assign cand  = (mode_q != MODE_STRICT) && elig_vec[eng_q] && health_q[eng_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eng_q      <= '0;
			best_vld_q <= 1'b0;
		end else if (cmd.scan_clr) begin
			eng_q      <= '0;
			best_vld_q <= 1'b0;
		end else if (cmd.scan_cmp) begin
			eng_q <= eng_q + EW'(1);
			if (cand && (!best_vld_q || score < best_score_q)) best_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_cmp && cand && (!best_vld_q || score < best_score_q)) begin
			best_q       <= eng_q;
			best_score_q <= score;
		end
	end

	// try order
	logic [EW-1:0]          pref_q;
	logic                   any_h_q;
	logic                   pend_q;
	logic [NUM_ENGINES-1:0] rem_q;
	logic [2:0]             n_q;
	logic [EW-1:0]          pref_d;
	logic [EW-1:0]          pick;
	logic [NUM_ENGINES-1:0] rem_nx;
	logic [EW-1:0]          e_idx;
	logic                   e_last;
	logic                   e_none;

	assign pref_d = ((mode_q != MODE_STRICT) && best_vld_q) ? best_q : lowest(health_q);
	assign pick   = lowest(rem_q);
	assign rem_nx = rem_q & ~(NUM_ENGINES'(1) << pick);

	always_comb begin
		e_none = 1'b0;
		if (mode_q == MODE_NOFAIL) begin
			e_idx  = any_h_q ? pref_q : '0;
			e_last = 1'b1;
			e_none = !any_h_q;
		end else if (pend_q) begin
			e_idx  = pref_q;
			e_last = (rem_q == '0);
		end else begin
			e_idx  = pick;
			e_last = (rem_nx == '0) || (n_q == 3'd7);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			n_q    <= '0;
		end else if (cmd.prep) begin
			pend_q <= |health_q;
			n_q    <= '0;
		end else if (cmd.emit) begin
			pend_q <= 1'b0;
			n_q    <= n_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			pref_q  <= pref_d;
			any_h_q <= |health_q;
			rem_q   <= (|health_q) ? (health_q & ~(NUM_ENGINES'(1) << pref_d)) : '1;
		end else if (cmd.emit && !pend_q) begin
			rem_q <= rem_nx;
		end
	end

	// output slot
	logic     out_valid_q;
	les_out_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit || cmd.ack) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q <= '{child_index: 3'(e_idx), last: e_last, none_available: e_none,
				healthy_mask: health_ext[7:0]};
		end else if (cmd.ack) begin
			out_q <= '{child_index: 3'd0, last: 1'b1, none_available: 1'b0,
				healthy_mask: health_ext[7:0]};
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	assign sts.child_ok  = child_ok;
	assign sts.scan_last = (eng_q == EW'(NUM_ENGINES - 1));
	assign sts.emit_last = e_last;
	assign sts.rep_valid = rd_vld_s1;
	assign sts.div_done  = div_done;
	assign sts.out_free  = !out_valid_q || out_ready;

	`LES_NEVER(a_div_restart, clk, arst_n, cmd.div_start && div_busy, "divider restarted while busy")
	`LES_ASSERT(a_wr_engine, clk, arst_n, cmd.rep_wr |-> child_ok, "latency written for absent engine")
endmodule

### rtl/latency_aware_engine_selector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// latency_aware_engine_selector
// Picks and orders the engines that serve a job from health and latency.
// ----------------------------------------------------------------------------
// Usage:
//  - in channel (in_valid/in_ready/in_item): one item per request, latency
//    report, failure, tick or forced health. One item is worked at a time.
//  - out channel (out_valid/out_ready/out_item): a request yields its try
//    order, one engine per item, last set on the final one; failure, tick and
//    force give one acknowledgement; reports give nothing.
//  - cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready;
//    write only while the block is idle.
//  - Request: refresh, then the score scan reads each latency memory entry
//    (read, then compare), prep, then one result a cycle while the slot is free.
//  - Latency report: the next item is taken once the bit-serial divider that
//    scales the average step is done; a first sample skips the divider.
//  - Failure and force update, then acknowledge; tick counts, refreshes, acks.
//  - Reset clears the sample valid bits, makes all engines healthy, zeroes
//    cooldowns and loads register defaults; no clearing pass is needed.
//  - A stalled receiver holds the output register; the sequencer waits
//    with the next result and accepts no new item until the order's last result is in the output register.
// ----------------------------------------------------------------------------
module latency_aware_engine_selector #(
	parameter int NUM_ENGINES = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  les_pkg::les_in_t  in_item,
	output logic              out_valid,
	input  logic              out_ready,
	output les_pkg::les_out_t out_item,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [31:0]       cfg_data
);
	import les_pkg::*;

	les_cmd_t cmd;
	les_sts_t sts;

	// Registers are plain flops; take a write in any cycle.
	assign cfg_ready = 1'b1;

	// Sequencer: one item at a time, drives the datapath step by step.
	les_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.req_type (in_item.req_type),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath: state, latency memory, divider and the output register.
	les_dp #(
		.NUM_ENGINES (NUM_ENGINES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);
endmodule

### test/les_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// les_checker
// Watches the selector's channels, predicts each try order and compares.
// ----------------------------------------------------------------------------
module les_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  les_pkg::les_in_t   in_item,
	input  logic               out_valid,
	input  logic               out_ready,
	input  les_pkg::les_out_t  out_item,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	output int                 pending,
	output int                 errors
);
	import les_pkg::*;

	localparam int ENGINES = 8;

	logic [31:0] avg_tab [ENGINES][NUM_BUCKETS];
	logic        avg_ok  [ENGINES][NUM_BUCKETS];
	logic [7:0]  health;
	logic [31:0] cool [ENGINES];
	logic [1:0]  sel_mode;
	logic [15:0] window;
	logic [31:0] cool_ticks;
	logic [7:0]  elig;
	les_out_t    order_q[$];

	assign pending = order_q.size();

	function automatic int bucket_idx(logic [19:0] size);
		int b;
		b = 0;
		while (b < NUM_BUCKETS - 1 && size >= (20'd128 << b)) b++;
		return b;
	endfunction

	function automatic void wake_idle();
		for (int e = 0; e < ENGINES; e++)
			if (!health[e] && cool[e] == 0) health[e] = 1'b1;
	endfunction

	function automatic int first_up();
		for (int e = 0; e < ENGINES; e++)
			if (health[e]) return e;
		return -1;
	endfunction

	function automatic void push_res(int idx, bit lst, bit nav);
		les_out_t r;
		r.child_index = 3'(idx);
		r.last = lst;
		r.none_available = nav;
		r.healthy_mask = health;
		order_q.insert(order_q.size(), r);
	endfunction

	function automatic void predict_order(logic [19:0] size);
		int pref, n, bk;
		logic [31:0] s, best_s;
		wake_idle();
		bk = bucket_idx(size);
		pref = -1;
		best_s = 0;
		if (sel_mode == MODE_STRICT) begin
			pref = first_up();
		end else begin
			for (int e = 0; e < ENGINES; e++) begin
				if (!elig[e] || !health[e]) continue;
				s = avg_ok[e][bk] ? avg_tab[e][bk] : SCORE_UNTRIED;
				if (pref < 0 || s < best_s) begin
					pref = e;
					best_s = s;
				end
			end
			if (pref < 0) pref = first_up();
		end
		if (sel_mode == MODE_NOFAIL) begin
			if (pref < 0) push_res(0, 1, 1);
			else push_res(pref, 1, 0);
			return;
		end
		n = 0;
		if (pref >= 0) begin
			push_res(pref, 0, 0);
			n++;
		end
		for (int e = 0; e < ENGINES; e++)
			if (e != pref && health[e]) begin
				push_res(e, 0, 0);
				n++;
			end
		if (n == 0)
			for (int e = 0; e < ENGINES; e++) push_res(e, 0, 0);
		order_q[$].last = 1'b1;
	endfunction

	function automatic void note_sample(int e, logic [19:0] size, logic [23:0] lat);
		int bk;
		logic [63:0] nv, prev, w;
		bk = bucket_idx(size);
		nv = {40'd0, lat} << 8;
		w = (window == 0) ? 64'd1 : {48'd0, window};
		if (avg_ok[e][bk]) begin
			prev = {32'd0, avg_tab[e][bk]};
			if (nv >= prev) nv = prev + (nv - prev) / w;
			else nv = prev - (prev - nv) / w;
		end
		avg_tab[e][bk] = nv[31:0];
		avg_ok[e][bk] = 1'b1;
	endfunction

	function automatic void predict_item(les_in_t it);
		case (it.req_type)
			REQ_ORDER: predict_order(it.job_size);
			REQ_REPORT: note_sample(it.child, it.job_size, it.lat_us);
			REQ_FAIL: begin
				health[it.child] = 1'b0;
				cool[it.child] = cool_ticks;
				push_res(0, 1, 0);
			end
			REQ_TICK: begin
				for (int e = 0; e < ENGINES; e++)
					if (!health[e] && cool[e] != 0) cool[e]--;
				wake_idle();
				push_res(0, 1, 0);
			end
			REQ_FORCE: begin
				health[it.child] = it.set_healthy;
				if (!it.set_healthy) cool[it.child] = cool_ticks;
				push_res(0, 1, 0);
			end
			default: ;
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		les_out_t exp_r;
		if (!arst_n) begin
			for (int e = 0; e < ENGINES; e++) begin
				cool[e] = 0;
				for (int b = 0; b < NUM_BUCKETS; b++) begin
					avg_ok[e][b] = 1'b0;
					avg_tab[e][b] = 0;
				end
			end
			health = 8'hFF;
			sel_mode = MODE_STRICT;
			window = 16'd1;
			cool_ticks = 0;
			elig = 8'hFF;
			order_q.delete();
			errors = 0;
		end else begin
			// check results first: an item accepted now cannot yield one this edge
			if (out_valid && out_ready) begin
				if (order_q.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected result %p", out_item);
				end else begin
					exp_r = order_q.pop_front();
					if (out_item !== exp_r) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: expected %p got %p", exp_r, out_item);
					end
				end
			end
			if (cfg_valid && cfg_ready)
				case (cfg_index)
					CFG_MODE: sel_mode = (cfg_data[1:0] == MODE_UNUSED) ?
						MODE_ADAPT : cfg_data[1:0];
					CFG_WINDOW: window = cfg_data[15:0];
					CFG_COOLDOWN: cool_ticks = cfg_data;
					CFG_ELIGIBLE: elig = cfg_data[7:0];
					default: ;
				endcase
			if (in_valid && in_ready) predict_item(in_item);
		end
	end

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives requests, reports, failures, ticks and forced health into the
// selector across several register settings, with random idling on both
// channels; the checker predicts every try order and counts mismatches.
// ----------------------------------------------------------------------------
module testbench;
	import les_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	les_in_t     in_item;
	logic        out_valid;
	logic        out_ready;
	les_out_t    out_item;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;
	int          pending;
	int          errors;
	bit          steady;  // when set, no idling on either side

	latency_aware_engine_selector dut (.*);

	les_checker checker_i (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Receiver: stall about 36 percent of the time, unless in a steady stretch.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= steady || ($urandom_range(99) >= 36);
		end
	end

	// Send one item: hold valid and payload until accepted. Valid stays high
	// after acceptance so the next item can follow; drop it before idling.
	task automatic send_item(les_in_t it);
		cfg_valid <= 1'b0;
		while (!steady && $urandom_range(99) < 36) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// Wait for the order to drain, plus the slowest item's own cycles.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	// Write one register; the next send drops cfg_valid.
	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	function automatic les_in_t make_item(logic [2:0] kind, logic [2:0] eng,
		logic [19:0] size, logic [23:0] lat, logic sh);
		les_in_t it;
		it.req_type = kind;
		it.child = eng;
		it.job_size = size;
		it.lat_us = lat;
		it.set_healthy = sh;
		return it;
	endfunction

	// Random size: mostly around bucket edges, sometimes anything.
	function automatic logic [19:0] rand_size();
		if ($urandom_range(3) == 0) return 20'($urandom);
		return 20'((128 << $urandom_range(10)) - $urandom_range(1));
	endfunction

	// Random item: weighted toward requests and reports so averages build up.
	function automatic les_in_t rand_item();
		int r;
		logic [2:0] kind;
		r = $urandom_range(99);
		if (r < 35) kind = REQ_ORDER;
		else if (r < 65) kind = REQ_REPORT;
		else if (r < 75) kind = REQ_FAIL;
		else if (r < 87) kind = REQ_TICK;
		else if (r < 97) kind = REQ_FORCE;
		else kind = 3'($urandom_range(7, 5));
		return make_item(kind, 3'($urandom), rand_size(),
			($urandom_range(7) == 0) ? 24'($urandom) : 24'($urandom_range(3000)),
			1'($urandom));
	endfunction

	initial begin
		in_valid = 1'b0;
		in_item = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_MODE;
		cfg_data = '0;
		steady = 1'b0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b0;
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// Directed: default strict mode, every kind and the field extremes.
		send_item(make_item(REQ_ORDER, 3'd0, 20'd0, 24'd0, 1'b0));
		send_item(make_item(REQ_ORDER, 3'd0, 20'hFFFFF, 24'd0, 1'b0));
		send_item(make_item(REQ_REPORT, 3'd7, 20'd127, 24'hFFFFFF, 1'b0));
		send_item(make_item(REQ_REPORT, 3'd7, 20'd127, 24'd0, 1'b0));
		send_item(make_item(REQ_REPORT, 3'd3, 20'd65536, 24'd1, 1'b0));
		send_item(make_item(REQ_FAIL, 3'd0, 20'd0, 24'd0, 1'b0));
		send_item(make_item(REQ_ORDER, 3'd0, 20'd128, 24'd0, 1'b0));
		send_item(make_item(REQ_FORCE, 3'd0, 20'd0, 24'd0, 1'b1));
		send_item(make_item(REQ_TICK, 3'd0, 20'd0, 24'd0, 1'b0));
		send_item(make_item(3'd7, 3'd2, 20'd0, 24'd0, 1'b1));
		drain();

		// Adaptive, long cooldown, and everything down.
		write_reg(CFG_MODE, 32'(MODE_ADAPT));
		write_reg(CFG_COOLDOWN, 32'd2);
		write_reg(CFG_WINDOW, 32'd0);
		for (int e = 0; e < 8; e++) send_item(make_item(REQ_FAIL, 3'(e), 20'd0, 24'd0, 1'b0));
		send_item(make_item(REQ_ORDER, 3'd0, 20'd300, 24'd0, 1'b0));
		send_item(make_item(REQ_TICK, 3'd0, 20'd0, 24'd0, 1'b0));
		send_item(make_item(REQ_TICK, 3'd0, 20'd0, 24'd0, 1'b0));
		send_item(make_item(REQ_ORDER, 3'd0, 20'd127, 24'd0, 1'b0));
		drain();

		// No failover with all down, then with one engine forced back up.
		write_reg(CFG_MODE, 32'(MODE_NOFAIL));
		for (int e = 0; e < 8; e++) send_item(make_item(REQ_FORCE, 3'(e), 20'd0, 24'd0, 1'b0));
		send_item(make_item(REQ_ORDER, 3'd0, 20'd5000, 24'd0, 1'b0));
		send_item(make_item(REQ_FORCE, 3'd5, 20'd0, 24'd0, 1'b1));
		send_item(make_item(REQ_ORDER, 3'd0, 20'd5000, 24'd0, 1'b0));
		drain();

		// Random phases across register settings, extremes among them.
		for (int ph = 0; ph < 5; ph++) begin
			write_reg(CFG_MODE, (ph == 4) ? 32'(MODE_UNUSED) : 32'(ph % 3));
			write_reg(CFG_WINDOW, (ph == 1) ? 32'hFFFF : 32'($urandom_range(8)));
			write_reg(CFG_COOLDOWN, (ph == 2) ? 32'hFFFFFFFF : 32'($urandom_range(4)));
			write_reg(CFG_ELIGIBLE, (ph == 3) ? 32'd0 : 32'($urandom_range(255)));
			steady = (ph == 2);
			for (int k = 0; k < 26; k++) begin
				send_item(rand_item());
				// let the whole order drain before going on, at least once
				if (ph == 0 && k == 10) begin
					in_valid <= 1'b0;
					@(posedge clk);
					while (pending != 0) @(posedge clk);
				end
			end
			steady = 1'b0;
			drain();
		end

		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
